// ----- hw/rtl/sorted_expiry_timer_queue_unit_macros.svh -----
// Assertion macros shared by the checker of the sorted expiry timer queue.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH

// Property checked at every rising edge of clk, ignored while rst is high.
`define SETQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define SETQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/setq_pkg.sv -----
// Types, codes and helpers of the sorted expiry timer queue.
`timescale 1ns / 1ps
package setq_pkg;

  localparam int ID_W   = 4;
  localparam int FUNC_W = 3;
  localparam int KIND_W = 2;
  localparam int HW_W   = 24;
  localparam int TIME_W = 32;

  localparam int NUM_TIMERS_DEF      = 16;
  localparam int HW_COUNTER_BITS_DEF = 24;

  localparam logic [FUNC_W-1:0] FN_START_AT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START_AFTER = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STOP        = 3'd2;
  localparam logic [FUNC_W-1:0] FN_EXPIRE      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ        = 3'd4;

  localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] tick_value;
    logic [HW_W-1:0]   hw_count;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   expired_id;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] reload_value;
    logic              force_irq;
    logic              last;
  } out_item_t;

  // One queue position: a timer id and its expiry.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } slot_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } cell_cmd_t;

  // An expiry is reached when it is not after now in wraparound order.
  function automatic logic is_due(input logic [TIME_W-1:0] expiry,
                                  input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = expiry - now;
    return (d == '0) || d[TIME_W-1];
  endfunction

endpackage

// ----- hw/rtl/setq_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
`timescale 1ns / 1ps
interface setq_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/setq_cell.sv -----
// One position of the sorted timer chain; shifts left on removal, right on insertion.
`timescale 1ns / 1ps
module setq_cell (
  input  logic              clk,
  input  logic              rst,
  input  setq_pkg::cell_cmd_t cmd,
  input  setq_pkg::slot_t   left_slot,
  input  setq_pkg::slot_t   right_slot,
  input  logic              flag_in,
  output logic              flag_out,
  output setq_pkg::slot_t   slot
);
  import setq_pkg::*;

  slot_t slot_next;
  logic  match;
  logic  ge;
  logic [TIME_W-1:0] diff;

  assign match = slot.valid && (slot.id == cmd.id);
  // The new timer goes after every entry whose expiry is not later than its own.
  assign diff = cmd.expiry - slot.expiry;
  assign ge   = slot.valid && !diff[TIME_W-1];

  always_comb begin
    slot_next = slot;
    flag_out  = flag_in;
    case (cmd.op)
      OP_REMOVE: begin
        flag_out = flag_in || match;
        if (flag_in || match) begin
          slot_next = right_slot;
        end
      end
      OP_INSERT: begin
        flag_out = flag_in || !ge;
        if (flag_in) begin
          slot_next = left_slot;
        end else if (!ge) begin
          slot_next.valid  = 1'b1;
          slot_next.id     = cmd.id;
          slot_next.expiry = cmd.expiry;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.id     <= slot_next.id;
    slot.expiry <= slot_next.expiry;
  end
endmodule

// ----- hw/rtl/sorted_expiry_timer_queue_unit.sv -----
// Sorted expiry timer queue: a chain of cells holds the timers in expiry order.
// Throughput: one item at a time; a new item is accepted only in the idle state.
// Each result waits in the output register until taken; the next item is accepted once the
// final result of the current one, if it has any, is in that register.
// Synchronous reset empties the chain and clears the extended time.
`timescale 1ns / 1ps
module sorted_expiry_timer_queue_unit #(
  parameter int NUM_TIMERS      = setq_pkg::NUM_TIMERS_DEF,
  parameter int HW_COUNTER_BITS = setq_pkg::HW_COUNTER_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  setq_stream_if.sink   req,
  setq_stream_if.source rsp
);
  import setq_pkg::*;

  localparam logic [TIME_W-1:0] CNT_STEP = TIME_W'(64'd1 << HW_COUNTER_BITS);
  localparam logic [TIME_W-1:0] CNT_MASK = CNT_STEP - TIME_W'(1);
  localparam logic [TIME_W-1:0] CNT_HALF = TIME_W'(64'd1 << (HW_COUNTER_BITS - 1));

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_REMOVE = 7'b0000010,
    ST_INSERT = 7'b0000100,
    ST_STOP   = 7'b0001000,
    ST_EXPIRE = 7'b0010000,
    ST_TRIG   = 7'b0100000,
    ST_READ   = 7'b1000000
  } state_t;

  state_t            state;
  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] tick_r;
  logic [HW_W-1:0]   hw_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] ext_time;
  logic              out_valid;
  out_item_t         out_data;

  cell_cmd_t         cmd;
  slot_t             slots [NUM_TIMERS];
  logic              flags [NUM_TIMERS+1];
  slot_t             head;
  logic              out_free;
  logic              out_load;
  logic              head_due;
  logic              id_ok;

  logic [HW_W-1:0]   sample_src;
  logic [TIME_W-1:0] sample_low;
  logic [TIME_W-1:0] sample_high;
  logic [TIME_W-1:0] sampled;

  assign head      = slots[0];
  assign out_free  = !out_valid || rsp.ready;
  assign head_due  = head.valid && is_due(head.expiry, now_r);
  assign out_load  = out_free && ((state == ST_EXPIRE && head_due) ||
                                  state == ST_TRIG || state == ST_READ);
  assign id_ok     = int'(req.data.timer_id) < NUM_TIMERS;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Extend the raw counter sample; the upper part steps when the counter wraps.
  always_comb begin
    sample_src  = (state == ST_IDLE) ? req.data.hw_count : hw_r;
    sample_low  = TIME_W'(sample_src) & CNT_MASK;
    sample_high = ext_time & ~CNT_MASK;
    if (sample_low < (ext_time & CNT_MASK)) begin
      sample_high = sample_high + CNT_STEP;
    end
    sampled = sample_high + sample_low;
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.id     = id_r;
    cmd.expiry = tick_r;
    case (state)
      ST_REMOVE, ST_STOP: begin
        cmd.op = OP_REMOVE;
      end
      ST_INSERT: begin
        cmd.op = OP_INSERT;
      end
      ST_EXPIRE: begin
        if (head_due && out_free) begin
          cmd.op = OP_REMOVE;
          cmd.id = head.id;
        end
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

  assign flags[0] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    if (i == 0) begin : g_first
      assign left_slot = '0;
    end else begin : g_mid
      assign left_slot = slots[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end
    setq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .flag_in    (flags[i]),
      .flag_out   (flags[i+1]),
      .slot       (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ext_time  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            id_r   <= req.data.timer_id;
            hw_r   <= req.data.hw_count;
            tick_r <= req.data.tick_value;
            case (req.data.func)
              FN_START_AT, FN_START_AFTER: begin
                if (id_ok) begin
                  ext_time <= sampled;
                  now_r    <= sampled;
                  if (req.data.func == FN_START_AFTER) begin
                    tick_r <= sampled + req.data.tick_value;
                  end
                  state <= ST_REMOVE;
                end
              end
              FN_STOP: begin
                if (id_ok) begin
                  state <= ST_STOP;
                end
              end
              FN_EXPIRE: begin
                ext_time <= sampled;
                now_r    <= sampled;
                state    <= ST_EXPIRE;
              end
              FN_READ: begin
                ext_time <= sampled;
                now_r    <= sampled;
                state    <= ST_READ;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_REMOVE: begin
          state <= ST_INSERT;
        end
        ST_INSERT: begin
          state <= ST_TRIG;
        end
        ST_STOP: begin
          // Only a stop of the head timer samples time and reports a new trigger.
          if (head.valid && head.id == id_r) begin
            ext_time <= sampled;
            now_r    <= sampled;
            state    <= ST_TRIG;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EXPIRE: begin
          if (head_due) begin
            if (out_free) begin
              out_data.kind         <= KIND_EXPIRED;
              out_data.expired_id   <= head.id;
              out_data.time_value   <= head.expiry;
              out_data.reload_value <= '0;
              out_data.force_irq    <= 1'b0;
              out_data.last         <= 1'b0;
            end
          end else begin
            state <= ST_TRIG;
          end
        end
        ST_TRIG: begin
          if (out_free) begin
            out_data.kind       <= KIND_TRIGGER;
            out_data.expired_id <= '0;
            out_data.time_value <= '0;
            out_data.last       <= 1'b1;
            if (head.valid) begin
              out_data.reload_value <= head.expiry;
              out_data.force_irq    <= head_due;
            end else begin
              out_data.reload_value <= now_r + CNT_HALF;
              out_data.force_irq    <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_data.kind         <= KIND_READ;
            out_data.expired_id   <= '0;
            out_data.time_value   <= now_r;
            out_data.reload_value <= '0;
            out_data.force_irq    <= 1'b0;
            out_data.last         <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- hw/rtl/setq_checker.sv -----
// Port-level checker of the sorted expiry timer queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_expiry_timer_queue_unit_macros.svh"
module setq_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input setq_pkg::out_item_t rsp_data
);
  import setq_pkg::*;

  `SETQ_ASSERT(a_rsp_hold,
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data),
    "result dropped or changed while stalled")
  `SETQ_ASSERT(a_kind_known,
    rsp_valid |-> (rsp_data.kind == KIND_TRIGGER || rsp_data.kind == KIND_EXPIRED ||
                   rsp_data.kind == KIND_READ),
    "unknown result kind")
  `SETQ_ASSERT(a_trig_last,
    rsp_valid && rsp_data.kind == KIND_TRIGGER |-> rsp_data.last,
    "trigger update is not the final result")
  `SETQ_ASSERT(a_read_last,
    rsp_valid && rsp_data.kind == KIND_READ |-> rsp_data.last && rsp_data.expired_id == '0,
    "time read malformed")
  `SETQ_ASSERT(a_exp_more,
    rsp_valid && rsp_data.kind == KIND_EXPIRED |-> !rsp_data.last && !rsp_data.force_irq,
    "expired timer result marked final")
endmodule

bind sorted_expiry_timer_queue_unit setq_checker u_setq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- tb/sorted_expiry_timer_queue_unit_tb.sv -----
// Self-checking testbench of the sorted expiry timer queue unit.
`timescale 1ns / 1ps
module sorted_expiry_timer_queue_unit_tb;
  import setq_pkg::*;

  localparam int NTIM = 16;
  localparam logic [31:0] CNT_MASK = 32'h00FF_FFFF;
  localparam logic [31:0] CNT_STEP = 32'h0100_0000;
  localparam logic [31:0] CNT_HALF = 32'h0080_0000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  setq_stream_if #(.T(in_item_t)) req ();
  setq_stream_if #(.T(out_item_t)) rsp ();

  sorted_expiry_timer_queue_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the timer queue.
  logic [31:0] ext_time;
  logic [31:0] expiry_of [NTIM];
  logic [3:0]  order_q [$];
  bit          running [NTIM];

  out_item_t expected_results [$];
  int mismatches;
  int cycles;
  logic [23:0] hw_now;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] sample_hw(logic [23:0] hw);
    logic [31:0] hi;
    hi = ext_time & ~CNT_MASK;
    if ({8'd0, hw} < (ext_time & CNT_MASK)) hi = hi + CNT_STEP;
    ext_time = hi + {8'd0, hw};
    return ext_time;
  endfunction

  function automatic bit reached(logic [31:0] e, logic [31:0] now);
    logic [31:0] d;
    d = e - now;
    return (d == 0) || d[31];
  endfunction

  function automatic out_item_t make_res(logic [1:0] k, logic [3:0] id, logic [31:0] tv,
                                         logic [31:0] rv, logic f);
    out_item_t r;
    r.kind = k;
    r.expired_id = id;
    r.time_value = tv;
    r.reload_value = rv;
    r.force_irq = f;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic out_item_t head_trigger(logic [31:0] now);
    logic [31:0] e;
    if (order_q.size() > 0) begin
      e = expiry_of[order_q[0]];
      return make_res(KIND_TRIGGER, '0, '0, e, reached(e, now));
    end
    return make_res(KIND_TRIGGER, '0, '0, now + CNT_HALF, 1'b0);
  endfunction

  function automatic void drop_timer(logic [3:0] id);
    foreach (order_q[i]) begin
      if (order_q[i] == id) begin
        order_q.delete(i);
        break;
      end
    end
    running[id] = 0;
  endfunction

  // Works out the results of one accepted transaction.
  function automatic void predict_queue(in_item_t it);
    out_item_t res [$];
    logic [31:0] now, e;
    int pos;
    case (it.func)
      FN_START_AT, FN_START_AFTER: begin
        now = sample_hw(it.hw_count);
        e = (it.func == FN_START_AFTER) ? now + it.tick_value : it.tick_value;
        if (running[it.timer_id]) drop_timer(it.timer_id);
        pos = 0;
        while (pos < order_q.size() && !((e - expiry_of[order_q[pos]]) & 32'h8000_0000))
          pos++;
        order_q.insert(pos, it.timer_id);
        expiry_of[it.timer_id] = e;
        running[it.timer_id] = 1;
        res.push_back(head_trigger(now));
      end
      FN_STOP: begin
        if (running[it.timer_id]) begin
          pos = (order_q[0] == it.timer_id) ? 0 : 1;
          drop_timer(it.timer_id);
          if (pos == 0) begin
            now = sample_hw(it.hw_count);
            res.push_back(head_trigger(now));
          end
        end
      end
      FN_EXPIRE: begin
        now = sample_hw(it.hw_count);
        while (order_q.size() > 0 && reached(expiry_of[order_q[0]], now)) begin
          res.push_back(make_res(KIND_EXPIRED, order_q[0], expiry_of[order_q[0]], '0, 1'b0));
          running[order_q[0]] = 0;
          void'(order_q.pop_front());
        end
        res.push_back(head_trigger(now));
      end
      FN_READ: begin
        now = sample_hw(it.hw_count);
        res.push_back(make_res(KIND_READ, '0, now, '0, 1'b0));
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  // Sender: bursts with random gaps; valid drops only for a gap.
  int burst_left;

  task automatic send_item(logic [2:0] f, logic [3:0] id, logic [31:0] tick,
                           logic [23:0] hw);
    in_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    it.func = f;
    it.timer_id = id;
    it.tick_value = tick;
    it.hw_count = hw;
    req.valid <= 1'b1;
    req.data <= it;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_queue(it);
  endtask

  // Receiver stalls on its own pattern: phases of free flow and of random stalls.
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 1) == 1);
        default: rsp.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp.data);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r !== rsp.data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, rsp.data);
        end
      end
    end
  end

  // Counter advances a random step; occasionally it wraps.
  function automatic logic [23:0] advance_hw(int max_step);
    hw_now = hw_now + 24'($urandom_range(0, max_step));
    return hw_now;
  endfunction

  task automatic test_directed();
    send_item(FN_READ, '0, '0, 24'h000000);
    send_item(FN_EXPIRE, '0, '0, 24'h000010);
    send_item(FN_START_AT, 4'd0, 32'h0000_0100, 24'h000020);
    send_item(FN_START_AT, 4'd15, 32'h0000_0100, 24'h000020);
    send_item(FN_START_AFTER, 4'd3, 32'hFFFF_FFFF, 24'h000030);
    send_item(FN_START_AFTER, 4'd7, 32'h0000_0000, 24'h000040);
    send_item(FN_START_AT, 4'd0, 32'h0000_0050, 24'h000050);
    send_item(FN_STOP, 4'd15, '0, 24'h000060);
    send_item(FN_STOP, 4'd9, '0, 24'h000070);
    send_item(FN_STOP, 4'd7, '0, 24'h000080);
    send_item(3'd5, 4'd1, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_item(3'd7, 4'd2, '0, 24'h0);
    send_item(FN_START_AFTER, 4'd5, 32'h8000_0000, 24'hFFFFFF);
    send_item(FN_READ, '0, '0, 24'hFFFFFF);
    send_item(FN_READ, '0, '0, 24'h000005);
    send_item(FN_EXPIRE, '0, '0, 24'h000200);
    send_item(FN_STOP, 4'd3, '0, 24'h000300);
    send_item(FN_STOP, 4'd5, '0, 24'h000400);
    send_item(FN_EXPIRE, '0, '0, 24'h000500);
    hw_now = 24'h000500;
  endtask

  task automatic test_full_queue_expire();
    logic [31:0] t;
    for (int i = 0; i < NTIM; i++) begin
      t = ext_time + 32'($urandom_range(1, 40));
      send_item(FN_START_AT, 4'(i), t, advance_hw(2));
    end
    hw_now = hw_now + 24'd200;
    send_item(FN_EXPIRE, '0, '0, hw_now);
  endtask

  task automatic test_random_ops(int n);
    logic [2:0] f;
    logic [31:0] tick;
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 28) f = FN_START_AT;
      else if (r < 55) f = FN_START_AFTER;
      else if (r < 72) f = FN_STOP;
      else if (r < 90) f = FN_EXPIRE;
      else if (r < 96) f = FN_READ;
      else f = 3'($urandom_range(5, 7));
      case ($urandom_range(0, 3))
        0: tick = $urandom();
        1: tick = ext_time + 32'($urandom_range(0, 3000)) - 32'd500;
        default: tick = 32'($urandom_range(0, 3000));
      endcase
      if (f == FN_START_AT && $urandom_range(0, 1)) tick = ext_time + tick[11:0];
      send_item(f, 4'($urandom_range(0, 15)), tick,
                ($urandom_range(0, 30) == 0) ? 24'($urandom()) : advance_hw(700));
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    cycles = 0;
    mismatches = 0;
    burst_left = 0;
    ext_time = 0;
    hw_now = 0;
    foreach (running[i]) running[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue_expire();
    test_random_ops(300);
    req.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
